// ----- hdl/lfba_pkg.sv -----
`default_nettype none

package lfba_pkg;

    localparam int DEF_NUM_BLOCKS = 512;

    // payload and register widths
    localparam int OP_W      = 2;
    localparam int BLOCK_W   = 9;
    localparam int CFG_W     = 10;
    localparam int BASE_W    = 9;
    localparam int CFG_IDX_W = 2;

    // map bits held by one cell of the chain
    localparam int CELL_BITS  = 64;
    localparam int CELL_IDX_W = $clog2(CELL_BITS);

    typedef enum logic [OP_W-1:0] {
        OP_FORMAT   = 2'd0,
        OP_ALLOCATE = 2'd1,
        OP_RELEASE  = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRONT = 2'd0,
        CFG_BACK  = 2'd1,
        CFG_BASE  = 2'd2
    } t_cfg_reg;

    // map update applied by every cell in the same cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_FORMAT,
        CELL_SET,
        CELL_CLEAR
    } t_cell_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_SCAN,
        ST_FINISH
    } t_state;

    // flags carried down the search chain
    typedef struct packed {
        logic found;
        logic any;
    } t_scan_flags;

    function automatic logic [CELL_IDX_W-1:0] lowest_set(input logic [CELL_BITS-1:0] v);
        logic [CELL_IDX_W-1:0] pos;
        pos = '0;
        for (int j = CELL_BITS - 1; j >= 0; j--) begin
            if (v[j]) begin
                pos = CELL_IDX_W'(j);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/lfba_cell.sv -----
`default_nettype none

module lfba_cell
    import lfba_pkg::*;
#(
    parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
    parameter int KW         = CFG_W,
    parameter int XW         = CFG_W,
    parameter int CELL_NUM   = 0
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cell_op              i_op,
    input  wire logic [KW-1:0]         i_target,
    input  wire logic [KW-1:0]         i_front,
    input  wire logic [KW-1:0]         i_back_start,
    input  wire logic [KW-1:0]         i_start,
    input  wire t_scan_flags           i_flags,
    input  wire logic [XW-1:0]         i_idx,
    output      t_scan_flags           o_flags,
    output      logic [XW-1:0]         o_idx
);

    localparam int BASE = CELL_NUM * CELL_BITS;

    logic [CELL_BITS-1:0]  r_used;
    logic [CELL_BITS-1:0]  n_used;
    logic [CELL_BITS-1:0]  free_bits;
    logic [CELL_BITS-1:0]  cand;
    t_scan_flags           r_flags;
    t_scan_flags           n_flags;
    logic [XW-1:0]         r_idx;
    logic [XW-1:0]         n_idx;

    always_comb begin
        logic [KW-1:0] gidx;
        logic          hit;
        logic          in_range;
        gidx      = '0;
        hit       = 1'b0;
        in_range  = 1'b0;
        n_used    = r_used;
        free_bits = '0;
        cand      = '0;
        for (int j = 0; j < CELL_BITS; j++) begin
            gidx     = KW'(BASE + j);
            hit      = (gidx == i_target);
            in_range = ((BASE + j) < NUM_BLOCKS);
            unique case (i_op)
                CELL_FORMAT: n_used[j] = (gidx < i_front) || (gidx >= i_back_start);
                CELL_SET:    n_used[j] = r_used[j] | hit;
                CELL_CLEAR:  n_used[j] = r_used[j] & ~hit;
                default:     n_used[j] = r_used[j];
            endcase
            // blocks past the end of the disk never count as free
            free_bits[j] = ~r_used[j] & in_range;
            cand[j]      = free_bits[j] & (gidx >= i_start);
        end
    end

    // first free block so far wins; otherwise this cell offers its own
    always_comb begin
        n_flags.found = i_flags.found | (|cand);
        n_flags.any   = i_flags.any | (|free_bits);
        if (i_flags.found) begin
            n_idx = i_idx;
        end else begin
            n_idx = XW'(BASE) + XW'(lowest_set(cand));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_flags <= '0;
        end else begin
            r_used  <= n_used;
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
    end

    assign o_flags = r_flags;
    assign o_idx   = r_idx;

endmodule

`default_nettype wire

// ----- hdl/lowest_free_block_allocator.sv -----
// Lowest-free block allocator. One used/free mark per block lives in a row of
// cells of 64 marks each, plus a next-free pointer. Format marks the reserved
// front and back regions used and frees the rest; allocate grants the pointer
// block, marks it used and searches on from there, or sets status when the
// pointer is past the end; release frees one block (block 0 and blocks past
// the end are ignored) and searches again from search_base. Every request
// gives exactly one result. The block takes one request at a time, in steps:
// it takes the request, updates the marks, lets a search token walk down the
// cell row cell by cell, and loads the result. The result sits in an
// output register, so a new request is taken while the previous result
// waits; that request then holds in its last cycle until the earlier result
// is read. After reset all marks read free at once.
`default_nettype none

module lowest_free_block_allocator
    import lfba_pkg::*;
#(
    parameter int NUM_BLOCKS = DEF_NUM_BLOCKS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output      logic                  o_in_ready,
    input  wire logic [OP_W-1:0]       i_operation,
    input  wire logic [BLOCK_W-1:0]    i_block,
    output      logic                  o_out_valid,
    input  wire logic                  i_out_ready,
    output      logic [BLOCK_W-1:0]    o_granted_block,
    output      logic                  o_status,
    output      logic                  o_free_left,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]      i_cfg_data
);

    localparam int NC    = (NUM_BLOCKS + CELL_BITS - 1) / CELL_BITS;
    localparam int XW    = $clog2(NC * CELL_BITS + 1);
    localparam int KW    = (XW > CFG_W) ? XW : CFG_W;
    localparam int CNT_W = $clog2(NC + 1);

    t_state                r_state;
    t_state                n_state;
    logic [CNT_W-1:0]      r_cnt;

    logic [CFG_W-1:0]      r_front;
    logic [CFG_W-1:0]      r_back;
    logic [BASE_W-1:0]     r_base;

    logic [XW-1:0]         r_next_free;
    t_cell_op              r_cell_op;
    t_cell_op              n_cell_op;
    logic [KW-1:0]         r_target;
    logic [KW-1:0]         n_target;
    logic [KW-1:0]         r_start;
    logic [KW-1:0]         n_start;
    logic                  r_upd;
    logic                  n_upd;
    logic [BLOCK_W-1:0]    r_granted;
    logic [BLOCK_W-1:0]    n_granted;
    logic                  r_status;
    logic                  n_status;

    logic                  r_out_valid;
    logic [BLOCK_W-1:0]    r_out_granted;
    logic                  r_out_status;
    logic                  r_out_free;

    logic                  in_accept;
    logic                  finish_fire;
    t_cell_op              cell_op;
    logic [KW-1:0]         back_start;
    logic [KW-1:0]         nf_ext;

    t_scan_flags           chain_flags [NC+1];
    logic [XW-1:0]         chain_idx   [NC+1];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_APPLY;
            ST_APPLY:  n_state = ST_SCAN;
            ST_SCAN:   if (r_cnt == CNT_W'(NC - 1)) n_state = ST_FINISH;
            ST_FINISH: if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready  = 1'b0;
        cell_op     = CELL_HOLD;
        finish_fire = 1'b0;
        unique case (r_state)
            ST_IDLE:   o_in_ready = 1'b1;
            ST_APPLY:  cell_op = r_cell_op;
            ST_SCAN:   cell_op = CELL_HOLD;
            ST_FINISH: finish_fire = !r_out_valid || i_out_ready;
            default:   o_in_ready = 1'b0;
        endcase
    end

    assign in_accept = i_in_valid && o_in_ready;
    assign nf_ext    = KW'(r_next_free);

    always_comb begin
        if (KW'(r_back) >= KW'(NUM_BLOCKS)) begin
            back_start = '0;
        end else begin
            back_start = KW'(NUM_BLOCKS) - KW'(r_back);
        end
    end

    // request decode against the current pointer
    always_comb begin
        n_cell_op = CELL_HOLD;
        n_target  = '0;
        n_start   = '0;
        n_upd     = 1'b0;
        n_granted = '0;
        n_status  = 1'b0;
        unique case (i_operation)
            OP_FORMAT: begin
                n_cell_op = CELL_FORMAT;
                n_upd     = 1'b1;
            end
            OP_ALLOCATE: begin
                if (nf_ext < KW'(NUM_BLOCKS)) begin
                    n_cell_op = CELL_SET;
                    n_target  = nf_ext;
                    n_start   = nf_ext;
                    n_upd     = 1'b1;
                    n_granted = nf_ext[BLOCK_W-1:0];
                end else begin
                    n_status = 1'b1;
                end
            end
            OP_RELEASE: begin
                if (i_block != '0 && KW'(i_block) < KW'(NUM_BLOCKS)) begin
                    n_cell_op = CELL_CLEAR;
                    n_target  = KW'(i_block);
                    n_start   = KW'(r_base);
                    n_upd     = 1'b1;
                end
            end
            default: n_cell_op = CELL_HOLD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_front     <= CFG_W'(5);
            r_back      <= CFG_W'(4);
            r_base      <= BASE_W'(4);
            r_next_free <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SCAN) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else begin
                r_cnt <= '0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FRONT: r_front <= i_cfg_data;
                    CFG_BACK:  r_back  <= i_cfg_data;
                    CFG_BASE:  r_base  <= i_cfg_data[BASE_W-1:0];
                    default:   r_base  <= r_base;
                endcase
            end
            if (finish_fire && r_upd) begin
                if (chain_flags[NC].found) begin
                    r_next_free <= chain_idx[NC];
                end else begin
                    r_next_free <= XW'(NUM_BLOCKS);
                end
            end
            if (finish_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cell_op <= n_cell_op;
            r_target  <= n_target;
            r_start   <= n_start;
            r_upd     <= n_upd;
            r_granted <= n_granted;
            r_status  <= n_status;
        end
        if (finish_fire) begin
            r_out_granted <= r_granted;
            r_out_status  <= r_status;
            r_out_free    <= chain_flags[NC].any;
        end
    end

    assign chain_flags[0] = '0;
    assign chain_idx[0]   = '0;

    for (genvar k = 0; k < NC; k++) begin : g_cell
        lfba_cell #(
            .NUM_BLOCKS (NUM_BLOCKS),
            .KW         (KW),
            .XW         (XW),
            .CELL_NUM   (k)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (cell_op),
            .i_target     (r_target),
            .i_front      (KW'(r_front)),
            .i_back_start (back_start),
            .i_start      (r_start),
            .i_flags      (chain_flags[k]),
            .i_idx        (chain_idx[k]),
            .o_flags      (chain_flags[k+1]),
            .o_idx        (chain_idx[k+1])
        );
    end

    assign o_out_valid     = r_out_valid;
    assign o_granted_block = r_out_granted;
    assign o_status        = r_out_status;
    assign o_free_left     = r_out_free;

`ifndef SYNTHESIS
    a_accept_starts_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_state == ST_APPLY)
        else $error("accepted request did not enter apply");

    a_pointer_only_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !finish_fire |=> $stable(r_next_free))
        else $error("next-free pointer moved outside finish");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(finish_fire))
        else $error("result appeared without a finished request");

    a_found_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (finish_fire && r_upd && chain_flags[NC].found) |=> r_next_free < XW'(NUM_BLOCKS))
        else $error("search found a block past the end");
`endif

endmodule

`default_nettype wire
